/* design/gshare_pkg.sv */
// ----------------------------------------------------------------------------
// gshare predictor package
// Shared constants, counter encoding and the result type of the gshare
// branch predictor.
// ----------------------------------------------------------------------------
package gshare_pkg;

	// default widest index and history
	localparam int INDEX_BITS_MAX_DEFAULT = 12;

	// index_bits register
	localparam int         CFG_W          = 4;
	localparam logic [3:0] INDEX_BITS_RST = 4'd8;

	// 2-bit saturating counter encoding
	typedef logic [1:0] ctr_t;
	localparam ctr_t CTR_STRONG_NOT_TAKEN = 2'd0;
	localparam ctr_t CTR_WEAK_NOT_TAKEN   = 2'd1;
	localparam ctr_t CTR_WEAK_TAKEN       = 2'd2;
	localparam ctr_t CTR_STRONG_TAKEN     = 2'd3;

	// result queue sizing
	localparam int OUT_DEPTH = 3;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 2;

	// one prediction result
	typedef struct packed {
		logic predicted_taken;
		logic mispredicted;
	} res_t;

	// counter moved one step toward the outcome
	function automatic ctr_t ctr_update(input ctr_t ctr, input logic outcome);
		ctr_t nxt;
		nxt = ctr;
		if (outcome) begin
			if (ctr != CTR_STRONG_TAKEN)
				nxt = ctr + 2'd1;
		end else begin
			if (ctr != CTR_STRONG_NOT_TAKEN)
				nxt = ctr - 2'd1;
		end
		return nxt;
	endfunction

endpackage

/* design/gshare_index.sv */
// ----------------------------------------------------------------------------
// gshare index generation
// Holds the global history and the index_bits register, and forms the table
// index from the request address and the history.
// ----------------------------------------------------------------------------
module gshare_hist_idx #(
	parameter int INDEX_BITS_MAX = gshare_pkg::INDEX_BITS_MAX_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gshare_pkg::CFG_W-1:0]  cfg_data,
	input  logic                          req_accept,
	input  logic [INDEX_BITS_MAX-1:0]     req_addr,
	input  logic                          req_taken,
	output logic [INDEX_BITS_MAX-1:0]     req_idx
);

	localparam int WW = 5;

	logic [gshare_pkg::CFG_W-1:0] index_bits_q;
	logic [INDEX_BITS_MAX-1:0]    hist_q;
	logic [INDEX_BITS_MAX:0]      hist_shift;
	logic [WW-1:0]                width_eff;
	logic [INDEX_BITS_MAX-1:0]    mask;

	// index width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			index_bits_q <= gshare_pkg::INDEX_BITS_RST;
		else if (cfg_we)
			index_bits_q <= cfg_data;
	end

	// clamp width to 1..INDEX_BITS_MAX
	always_comb begin
		width_eff = WW'(index_bits_q);
		if (index_bits_q == '0)
			width_eff = WW'(1);
		else if (WW'(index_bits_q) > WW'(INDEX_BITS_MAX))
			width_eff = WW'(INDEX_BITS_MAX);
	end

	// low-bit mask of the active width
	always_comb begin
		for (int i = 0; i < INDEX_BITS_MAX; i++)
			mask[i] = (WW'(i) < width_eff);
	end

	assign req_idx = (req_addr ^ hist_q) & mask;

	// global history, newest outcome in bit 0
	assign hist_shift = {hist_q, req_taken};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hist_q <= '0;
		else if (req_accept)
			hist_q <= hist_shift[INDEX_BITS_MAX-1:0];
	end

endmodule

/* design/gshare_table.sv */
// ----------------------------------------------------------------------------
// gshare counter table
// Counter memory with read-modify-write, forwarding of the previous write,
// and a clearing pass after reset that sets every counter to weakly taken.
// ----------------------------------------------------------------------------
module gshare_table #(
	parameter int INDEX_BITS_MAX = gshare_pkg::INDEX_BITS_MAX_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic [INDEX_BITS_MAX-1:0]  req_idx,
	input  logic                       req_taken,
	output logic                       clearing,
	output logic                       res_valid,
	output gshare_pkg::res_t           res
);

	localparam int DEPTH = 1 << INDEX_BITS_MAX;

	gshare_pkg::ctr_t mem [DEPTH];
	gshare_pkg::ctr_t rd_data_q;

	logic                      clr_busy_q;
	logic [INDEX_BITS_MAX-1:0] clr_idx_q;

	logic                      valid_s1;
	logic [INDEX_BITS_MAX-1:0] idx_s1;
	logic                      taken_s1;

	logic                      wr_valid_q;
	logic [INDEX_BITS_MAX-1:0] wr_idx_q;
	gshare_pkg::ctr_t          wr_data_q;

	gshare_pkg::ctr_t          ctr_cur;
	gshare_pkg::ctr_t          ctr_new;
	logic                      mem_we;
	logic [INDEX_BITS_MAX-1:0] mem_waddr;
	gshare_pkg::ctr_t          mem_wdata;

	// clearing pass over the whole table after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (&clr_idx_q)
				clr_busy_q <= 1'b0;
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	assign clearing = clr_busy_q;

	// request stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		idx_s1   <= req_idx;
		taken_s1 <= req_taken;
	end

	// forward the write made at the edge of the read
	always_comb begin
		ctr_cur = rd_data_q;
		if (wr_valid_q && (wr_idx_q == idx_s1))
			ctr_cur = wr_data_q;
	end

	assign ctr_new = gshare_pkg::ctr_update(ctr_cur, taken_s1);

	// prediction and miss
	always_comb begin
		res.predicted_taken = ctr_cur[1];
		res.mispredicted    = ctr_cur[1] ^ taken_s1;
	end
	assign res_valid = valid_s1;

	// write port shared by clearing and updates
	always_comb begin
		mem_we    = clr_busy_q || valid_s1;
		mem_waddr = clr_busy_q ? clr_idx_q : idx_s1;
		mem_wdata = clr_busy_q ? gshare_pkg::CTR_WEAK_TAKEN : ctr_new;
	end

	// last write for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wr_valid_q <= 1'b0;
		else
			wr_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		wr_idx_q  <= idx_s1;
		wr_data_q <= ctr_new;
	end

	// counter memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_data_q <= mem[req_idx];
	end

	// no request during the clearing pass
	a_no_req_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |-> !clr_busy_q)
		else $error("request accepted during clearing pass");

	// every request reaches the update stage next cycle
	a_req_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |=> valid_s1)
		else $error("request lost before update stage");

	// forwarded entry matches the update that wrote it
	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid_q |-> $past(valid_s1))
		else $error("forwarding register without prior update");

endmodule

/* design/gshare_out_fifo.sv */
// ----------------------------------------------------------------------------
// gshare result queue
// Small queue that holds results while the output side stalls.
// ----------------------------------------------------------------------------
module gshare_out_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  gshare_pkg::res_t                    push_data,
	input  logic                                pop,
	output logic                                not_empty,
	output gshare_pkg::res_t                    head,
	output logic [gshare_pkg::OUT_CNT_W-1:0]    count
);

	gshare_pkg::res_t                  entries [gshare_pkg::OUT_DEPTH];
	logic [gshare_pkg::OUT_PTR_W-1:0]  wptr_q;
	logic [gshare_pkg::OUT_PTR_W-1:0]  rptr_q;
	logic [gshare_pkg::OUT_CNT_W-1:0]  count_q;

	function automatic logic [gshare_pkg::OUT_PTR_W-1:0] ptr_inc(
		input logic [gshare_pkg::OUT_PTR_W-1:0] p);
		logic [gshare_pkg::OUT_PTR_W-1:0] n;
		n = p + 1'b1;
		if (p == gshare_pkg::OUT_PTR_W'(gshare_pkg::OUT_DEPTH - 1))
			n = '0;
		return n;
	endfunction

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= ptr_inc(wptr_q);
			if (pop)
				rptr_q <= ptr_inc(rptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			entries[wptr_q] <= push_data;
	end

	assign not_empty = (count_q != '0);
	assign head      = entries[rptr_q];
	assign count     = count_q;

	// never pushed when full, unless also popped
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != gshare_pkg::OUT_CNT_W'(gshare_pkg::OUT_DEPTH)) || pop)
		else $error("result queue overflow");

	// never popped when empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("result queue underflow");

endmodule

/* design/gshare_branch_predictor_unit.sv */
// ----------------------------------------------------------------------------
// gshare branch predictor unit
// Predicts each resolved branch from a table of 2-bit counters indexed by
// address XOR global history, reports prediction and miss, then updates.
//
//   channel   signals                               direction
//   request   in_valid, in_stall, branch_address,   in (in_stall out)
//             taken
//   result    out_valid, out_stall,                  out (out_stall in)
//             predicted_taken, mispredicted
//   config    cfg_valid, cfg_ready, index_bits       in (cfg_ready out)
//
// One request per cycle while in_stall is low; a result passes the table read
// register, then the counter update with forwarding, and is pushed into the
// result queue before it is offered.
// After reset a clearing pass writes every counter with in_stall high;
// configuration writes are taken.
// A three-entry result queue absorbs output stalls; in_stall rises when it
// and the update stage together would overfill it.
// ----------------------------------------------------------------------------
module gshare_branch_predictor_unit #(
	parameter int INDEX_BITS_MAX = gshare_pkg::INDEX_BITS_MAX_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [31:0]                   branch_address,
	input  logic                          taken,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          predicted_taken,
	output logic                          mispredicted,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gshare_pkg::CFG_W-1:0]  index_bits
);

	logic                                 in_accept;
	logic [INDEX_BITS_MAX-1:0]            req_idx;
	logic                                 clearing;
	logic                                 res_valid;
	gshare_pkg::res_t                     res;
	gshare_pkg::res_t                     head;
	logic                                 pop;
	logic [gshare_pkg::OUT_CNT_W-1:0]     q_count;
	logic [gshare_pkg::OUT_CNT_W:0]       occupancy;

	// configuration always ready
	assign cfg_ready = 1'b1;

	// request acceptance
	assign occupancy = {1'b0, q_count} + (gshare_pkg::OUT_CNT_W + 1)'(res_valid);
	assign in_stall  = clearing ||
		(occupancy >= (gshare_pkg::OUT_CNT_W + 1)'(gshare_pkg::OUT_DEPTH));
	assign in_accept = in_valid && !in_stall;

	gshare_hist_idx #(
		.INDEX_BITS_MAX (INDEX_BITS_MAX)
	) u_index (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (index_bits),
		.req_accept (in_accept),
		.req_addr   (branch_address[INDEX_BITS_MAX-1:0]),
		.req_taken  (taken),
		.req_idx    (req_idx)
	);

	gshare_table #(
		.INDEX_BITS_MAX (INDEX_BITS_MAX)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_accept),
		.req_idx   (req_idx),
		.req_taken (taken),
		.clearing  (clearing),
		.res_valid (res_valid),
		.res       (res)
	);

	// result queue
	assign pop = out_valid && !out_stall;

	gshare_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (pop),
		.not_empty (out_valid),
		.head      (head),
		.count     (q_count)
	);

	assign predicted_taken = head.predicted_taken;
	assign mispredicted    = head.mispredicted;

	// queue plus update stage never exceed the queue depth
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= (gshare_pkg::OUT_CNT_W + 1)'(gshare_pkg::OUT_DEPTH))
		else $error("result capacity exceeded");

endmodule

/* tb/gshare_branch_predictor_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshare branch predictor unit testbench
// Drives resolved branches through the predictor under random request and
// result stalls, keeps a shadow counter table and history to work out each
// prediction, and checks every result in order. The index width is changed
// between phases, including the clamped widths zero and above twelve.
// ----------------------------------------------------------------------------
module gshare_branch_predictor_unit_test;

	localparam int HIST_W      = gshare_pkg::INDEX_BITS_MAX_DEFAULT;
	localparam int TABLE_SIZE  = 1 << HIST_W;
	// no request is taken during the clearing pass after reset
	localparam int STALL_LIMIT = 20000;

	// shadow of the counter table and history, with the predictions still owed
	class prediction_scoreboard;
		gshare_pkg::ctr_t  shadow_counters [TABLE_SIZE];
		logic [HIST_W-1:0] shadow_history;
		logic [gshare_pkg::CFG_W-1:0] width_reg;
		gshare_pkg::res_t  expected_predictions [$];
		int          errors;
		int          branches;
		int          misses;

		function new();
			foreach (shadow_counters[i])
				shadow_counters[i] = gshare_pkg::CTR_WEAK_TAKEN;
			shadow_history = '0;
			width_reg = gshare_pkg::INDEX_BITS_RST;
			errors = 0;
			branches = 0;
			misses = 0;
		endfunction

		function void set_width(logic [gshare_pkg::CFG_W-1:0] value);
			width_reg = value;
		endfunction

		function int pending();
			return expected_predictions.size();
		endfunction

		// predict from the indexed counter, then train counter and history
		function void note_branch(logic [31:0] addr, logic outcome);
			int                width;
			logic [HIST_W-1:0] mask;
			logic [HIST_W-1:0] slot;
			gshare_pkg::ctr_t  ctr;
			gshare_pkg::res_t  pred;
			width = int'(width_reg);
			if (width < 1)
				width = 1;
			if (width > HIST_W)
				width = HIST_W;
			mask = ({{HIST_W-1{1'b0}}, 1'b1} << width) - 1'b1;
			if (width == HIST_W)
				mask = '1;
			slot = (addr[HIST_W-1:0] ^ shadow_history) & mask;
			ctr = shadow_counters[slot];
			pred.predicted_taken = (ctr == gshare_pkg::CTR_WEAK_TAKEN) ||
				(ctr == gshare_pkg::CTR_STRONG_TAKEN);
			pred.mispredicted = pred.predicted_taken != outcome;
			expected_predictions.push_back(pred);
			branches++;
			if (pred.mispredicted)
				misses++;
			if (outcome && ctr != gshare_pkg::CTR_STRONG_TAKEN)
				ctr = ctr + 2'd1;
			else if (!outcome && ctr != gshare_pkg::CTR_STRONG_NOT_TAKEN)
				ctr = ctr - 2'd1;
			shadow_counters[slot] = ctr;
			shadow_history = {shadow_history[HIST_W-2:0], outcome};
		endfunction

		// compare one result against the oldest prediction owed
		function void check_prediction(logic pt, logic mp);
			gshare_pkg::res_t want;
			if (expected_predictions.size() == 0) begin
				$error("unexpected result: predicted_taken %0b mispredicted %0b", pt, mp);
				errors++;
				return;
			end
			want = expected_predictions.pop_front();
			if (pt !== want.predicted_taken) begin
				$error("predicted_taken: expected %0b, actual %0b", want.predicted_taken, pt);
				errors++;
			end
			if (mp !== want.mispredicted) begin
				$error("mispredicted: expected %0b, actual %0b", want.mispredicted, mp);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [31:0]       branch_address;
	logic              taken;
	logic              out_valid;
	logic              out_stall;
	logic              predicted_taken;
	logic              mispredicted;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [gshare_pkg::CFG_W-1:0] index_bits;

	prediction_scoreboard sb;
	bit                   quiet;
	int                   widths_used;

	gshare_branch_predictor_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.branch_address  (branch_address),
		.taken           (taken),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.predicted_taken (predicted_taken),
		.mispredicted    (mispredicted),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.index_bits      (index_bits)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side back-pressure
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= !quiet && ($urandom_range(0, 99) < 16);
		end
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_prediction(predicted_taken, mispredicted);
	end

	// watchdog on cycles with no handshake at all
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL gshare_branch_predictor_unit");
		$finish;
	end

	// one branch request, held until taken; entered and left at a falling edge
	task automatic send_branch(logic [31:0] addr, logic outcome);
		while (!quiet && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		branch_address <= addr;
		taken <= outcome;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		sb.note_branch(addr, outcome);
		@(negedge clk);
	endtask

	// stop requests and wait for every result, plus pipeline slack
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// index width write, only while the block is idle
	task automatic write_width(logic [gshare_pkg::CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		index_bits <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_width(value);
		widths_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// a pool of recurring branches with strong or mixed bias, plus noise
	task automatic run_phase(int count);
		logic [31:0] pool_addr [12];
		int          pool_bias [12];
		int          bias_choice [4];
		int          k;
		bias_choice = '{3, 97, 50, 85};
		foreach (pool_addr[i]) begin
			pool_addr[i] = $urandom;
			pool_bias[i] = bias_choice[$urandom_range(0, 3)];
		end
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 15) begin
				send_branch($urandom, 1'($urandom_range(0, 1)));
			end else begin
				k = $urandom_range(0, 11);
				send_branch(pool_addr[k], $urandom_range(0, 99) < pool_bias[k]);
			end
		end
	endtask

	// stimulus
	initial begin
		logic [gshare_pkg::CFG_W-1:0] phase_widths [8];
		sb = new();
		quiet = 1'b0;
		widths_used = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		branch_address = '0;
		taken = 1'b0;
		cfg_valid = 1'b0;
		index_bits = gshare_pkg::INDEX_BITS_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: address extremes, both outcomes, counters driven to saturation
		send_branch(32'h0000_0000, 1'b0);
		send_branch(32'hFFFF_FFFF, 1'b1);
		send_branch(32'h0000_0000, 1'b1);
		send_branch(32'hFFFF_FFFF, 1'b0);
		repeat (14) send_branch(32'h8000_1234, 1'b1);
		repeat (6) send_branch(32'h8000_1234, 1'b0);
		drain();

		// random phases over several widths, the clamped ones among them
		phase_widths = '{4'd0, 4'd1, 4'd12, 4'd15, 4'd5, 4'd13, 4'd3, 4'd8};
		phase_widths[6] = gshare_pkg::CFG_W'($urandom_range(0, 15));
		foreach (phase_widths[p]) begin
			write_width(phase_widths[p]);
			quiet = (p == 3);
			run_phase(120);
			drain();
			quiet = 1'b0;
		end

		repeat (8) @(posedge clk);
		$display("covered %0d branches over %0d index width settings, %0d mispredicted",
			sb.branches, widths_used, sb.misses);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS gshare_branch_predictor_unit");
		else
			$display("FAIL gshare_branch_predictor_unit");
		$finish;
	end

endmodule
